@@ rtl/pdd_pkg.sv @@
// Package for the prompt-delimited response deframer.
// Holds shared constants, the register map and the control/status structs.
// No dependencies.
package pdd_pkg;

  localparam int MAX_PENDING_STRIP = 8;
  localparam int CNT_W = $clog2(MAX_PENDING_STRIP + 1);

  localparam logic [7:0] PROMPT_RESET = 8'h3E;
  localparam logic [7:0] STRIP_RESET  = 8'h0D;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Register index, taken from the word address
  typedef enum logic {
    REG_PROMPT = 1'b0,
    REG_STRIP  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] prompt_char;
    logic [7:0] strip_char;
  } cfg_t;

  // Source of the byte loaded into the output register
  typedef enum logic {
    SEL_HELD  = 1'b0,
    SEL_STRIP = 1'b1
  } out_sel_t;

  typedef struct packed {
    logic     ld_out;
    out_sel_t out_sel;
    logic     out_last;
    logic     count_inc;
    logic     count_clr;
    logic     count_dec;
    logic     cap_new;
    logic     hold_rx;
    logic     hold_new;
    logic     clr_held;
  } dp_cmd_t;

  typedef struct packed {
    logic is_prompt;
    logic is_strip;
    logic held_valid;
    logic count_zero;
    logic count_one;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/pdd_stream_if.sv @@
// Valid/ready stream interfaces for the deframer's input and output channels.
// No dependencies.
interface pdd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pdd_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

@@ rtl/pdd_ctrl.sv @@
// Deframer controller: sequences acceptance and the emission of held and strip bytes.
// Depends on pdd_pkg.
module pdd_ctrl import pdd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LAST  = 4'b0010,
    ST_HELD  = 4'b0100,
    ST_STRIP = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.out_sel = SEL_HELD;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (status.is_prompt) begin
            cmd.count_clr = 1'b1;
            if (status.held_valid) begin
              state_next = ST_LAST;
            end
          end else if (status.is_strip) begin
            cmd.count_inc = 1'b1;
          end else begin
            cmd.cap_new = 1'b1;
            if (status.held_valid) begin
              state_next = ST_HELD;
            end else if (!status.count_zero) begin
              state_next = ST_STRIP;
            end else begin
              cmd.hold_rx = 1'b1;
            end
          end
        end
      end
      ST_LAST: begin
        if (status.out_free) begin
          cmd.ld_out   = 1'b1;
          cmd.out_last = 1'b1;
          cmd.clr_held = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_HELD: begin
        if (status.out_free) begin
          cmd.ld_out = 1'b1;
          if (status.count_zero) begin
            cmd.hold_new = 1'b1;
            state_next   = ST_IDLE;
          end else begin
            state_next = ST_STRIP;
          end
        end
      end
      ST_STRIP: begin
        if (status.out_free) begin
          cmd.ld_out    = 1'b1;
          cmd.out_sel   = SEL_STRIP;
          cmd.count_dec = 1'b1;
          if (status.count_one) begin
            cmd.hold_new = 1'b1;
            state_next   = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/pdd_datapath.sv @@
// Deframer datapath: held byte, strip counter, new-byte buffer, output register.
// Depends on pdd_pkg.
module pdd_datapath import pdd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic [7:0] rx_byte,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic [7:0]       held_byte;
  logic             held_valid;
  logic [CNT_W-1:0] pending_strip_count;
  logic [7:0]       new_byte;

  assign status.is_prompt  = (rx_byte == cfg.prompt_char);
  assign status.is_strip   = (rx_byte == cfg.strip_char);
  assign status.held_valid = held_valid;
  assign status.count_zero = (pending_strip_count == '0);
  assign status.count_one  = (pending_strip_count == CNT_W'(1));
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte           <= '0;
      held_valid          <= 1'b0;
      pending_strip_count <= '0;
      out_valid           <= 1'b0;
    end else begin
      // strip counter saturates; extra strip bytes are dropped
      if (cmd.count_clr || cmd.hold_new) begin
        pending_strip_count <= '0;
      end else if (cmd.count_inc) begin
        if (pending_strip_count < CNT_W'(MAX_PENDING_STRIP)) begin
          pending_strip_count <= pending_strip_count + CNT_W'(1);
        end
      end else if (cmd.count_dec) begin
        pending_strip_count <= pending_strip_count - CNT_W'(1);
      end

      if (cmd.clr_held) begin
        held_byte  <= '0;
        held_valid <= 1'b0;
      end else if (cmd.hold_rx) begin
        held_byte  <= rx_byte;
        held_valid <= 1'b1;
      end else if (cmd.hold_new) begin
        held_byte  <= new_byte;
        held_valid <= 1'b1;
      end

      if (cmd.ld_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_new) begin
      new_byte <= rx_byte;
    end
    if (cmd.ld_out) begin
      out_byte <= (cmd.out_sel == SEL_STRIP) ? cfg.strip_char : held_byte;
      out_last <= cmd.out_last;
    end
  end

endmodule

@@ rtl/prompt_delimited_response_deframer.sv @@
// Prompt-delimited response deframer, top level: register port and core.
// Throughput: one byte per cycle when it causes no result; a byte with results
// blocks new input until all its results (up to 1 + MAX_PENDING_STRIP) are
// loaded into the output register, which the controller loads one result per
// cycle while that register is free. The first result passes the controller state register, then the output register.
// Reset (rst, synchronous): registers to 0x3E / 0x0D, nothing held, no output.
module prompt_delimited_response_deframer import pdd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  pdd_rx_if.sink            rx,
  pdd_tx_if.source          tx,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;
  reg_idx_t   reg_idx;
  logic       cfg_wr;

  // Word-aligned register map: bit 2 selects the register, low bits ignored
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prompt_char <= PROMPT_RESET;
      cfg.strip_char  <= STRIP_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_PROMPT: cfg.prompt_char <= pwdata[7:0];
        REG_STRIP:  cfg.strip_char  <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Read back the selected register, zero-extended
  always_comb begin
    case (reg_idx)
      REG_PROMPT: prdata = {{(DATA_W-8){1'b0}}, cfg.prompt_char};
      REG_STRIP:  prdata = {{(DATA_W-8){1'b0}}, cfg.strip_char};
      default:    prdata = '0;
    endcase
  end

  // Controller: accepts a request only while no emission is pending
  pdd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_ready (rx.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: hold the newest data byte, count trailing strips, drive output
  pdd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rx_byte   (rx.rx_byte),
    .cmd       (cmd),
    .status    (status),
    .out_ready (tx.ready),
    .out_valid (tx.valid),
    .out_byte  (tx.out_byte),
    .out_last  (tx.last)
  );

endmodule
